// ===== src/csd_pkg.sv =====
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types and constants of the COBS stream deframer: verdict codes,
// frame error codes, the deframer state record and the result record.
// ----------------------------------------------------------------------------
package csd_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 13;
   localparam int VERD_W  = 3;
   localparam int CSR_IDX_W = 2;

   // Verdict codes carried on a frame end transaction.
   localparam logic [VERD_W-1:0] VERD_GOOD      = 3'd0;
   localparam logic [VERD_W-1:0] VERD_EMPTY     = 3'd1;
   localparam logic [VERD_W-1:0] VERD_RESYNC    = 3'd2;
   localparam logic [VERD_W-1:0] VERD_MALFORMED = 3'd3;
   localparam logic [VERD_W-1:0] VERD_TOO_LARGE = 3'd4;
   localparam logic [VERD_W-1:0] VERD_TOO_SHORT = 3'd5;

   // Frame error codes; the capacity hit inside a group is decided later.
   localparam logic [VERD_W-1:0] ERR_NONE           = 3'd0;
   localparam logic [VERD_W-1:0] ERR_TOO_LARGE      = 3'd4;
   localparam logic [VERD_W-1:0] ERR_LARGE_IN_GROUP = 3'd6;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FRAME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENC_LIMIT = 2'd2;

   localparam logic [BYTE_W-1:0] CODE_FULL_GROUP = 8'hFF;

   localparam logic [COUNT_W-1:0] MAX_FRAME_RESET = 13'd4096;
   localparam logic [COUNT_W-1:0] MIN_FRAME_RESET = 13'd8;
   localparam logic [COUNT_W-1:0] ENC_LIMIT_RESET = 13'd4113;

   typedef struct packed {
      logic [BYTE_W-1:0]  group_left;
      logic               group_was_full;
      logic               zero_owed;
      logic [COUNT_W-1:0] decoded_count;
      logic [COUNT_W-1:0] encoded_count;
      logic               discarding;
      logic [VERD_W-1:0]  frame_error;
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               frame_end;
      logic [VERD_W-1:0]  verdict;
      logic [COUNT_W-1:0] frame_length;
   } result_type;

   typedef struct packed {
      logic [COUNT_W-1:0] capacity;
      logic [COUNT_W-1:0] min_frame_bytes;
      logic [COUNT_W-1:0] encoded_limit;
   } config_type;

   localparam state_type STATE_RESET = '{
      group_left: '0, group_was_full: 1'b0, zero_owed: 1'b0,
      decoded_count: '0, encoded_count: '0, discarding: 1'b0,
      frame_error: ERR_NONE};

   // Drops the frame in progress; the discard flag is left alone.
   function automatic state_type clear_frame(input state_type s);
      state_type r;
      r = STATE_RESET;
      r.discarding = s.discarding;
      return r;
   endfunction

endpackage

// ===== src/csd_if.sv =====
// ----------------------------------------------------------------------------
// csd_if
// Valid/ready channel interfaces of the COBS stream deframer: wire bytes in,
// decoded bytes and verdicts out, and register writes.
// ----------------------------------------------------------------------------
interface csd_req_if;
   logic                         valid;
   logic                         ready;
   logic [csd_pkg::BYTE_W-1:0]   wire_byte;
   logic                         gap_before;

   modport source (output valid, output wire_byte, output gap_before, input ready);
   modport sink   (input valid, input wire_byte, input gap_before, output ready);
endinterface

interface csd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [csd_pkg::BYTE_W-1:0]   out_byte;
   logic                         frame_end;
   logic [csd_pkg::VERD_W-1:0]   verdict;
   logic [csd_pkg::COUNT_W-1:0]  frame_length;

   modport source (output valid, output out_byte, output frame_end, output verdict,
                   output frame_length, input ready);
   modport sink   (input valid, input out_byte, input frame_end, input verdict,
                   input frame_length, output ready);
endinterface

interface csd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [csd_pkg::CSR_IDX_W-1:0]  index;
   logic [csd_pkg::COUNT_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/cobs_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// cobs_stream_deframer
// Streaming COBS deframer: one wire byte per transaction, decoded bytes out as
// they are recovered, and one verdict transaction per zero delimiter.
// ----------------------------------------------------------------------------
// Path: a wire byte is held in the input register, and its result is held in
// the result register, which drives rsp_ch.
// Throughput: one wire byte per cycle while rsp_ch takes results, set by the
// combinational state update between the input register and result register.
// Reset: synchronous, active high; clears the frame state, the discard flag,
// both valid flags and loads the register defaults (4096, 8, 4113).
// ----------------------------------------------------------------------------
module cobs_stream_deframer #(
   parameter int MAX_FRAME = 4096
) (
   input  logic               clock,
   input  logic               reset,
   csd_req_if.sink            req_ch,
   csd_rsp_if.source          rsp_ch,
   csd_csr_if.sink            csr_ch
);

   // Capacity ceiling from the build parameter, clipped to the counter width.
   localparam int CAP_LIMIT = (MAX_FRAME > (2**csd_pkg::COUNT_W - 1))
                              ? (2**csd_pkg::COUNT_W - 1) : MAX_FRAME;
   localparam logic [csd_pkg::COUNT_W-1:0] CAP_CEIL = csd_pkg::COUNT_W'(CAP_LIMIT);

   // Configuration registers.
   logic [csd_pkg::COUNT_W-1:0] max_frame_ff;
   logic [csd_pkg::COUNT_W-1:0] min_frame_ff;
   logic [csd_pkg::COUNT_W-1:0] enc_limit_ff;
   csd_pkg::config_type         cfg;

   // Input register stage.
   logic                        in_valid_ff;
   logic [csd_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                        in_gap_ff;

   // Deframer state and result register.
   csd_pkg::state_type          state_ff;
   csd_pkg::state_type          state_in;
   logic                        rsp_valid_ff;
   csd_pkg::result_type         rsp_ff;

   logic                        step_valid;
   csd_pkg::result_type         step_result;
   logic                        out_free;
   logic                        advance;
   logic                        req_fire;

   // Register writes must be issued only while the block is idle, which the block
   // does not enforce. The port is always ready. An index past the register list is ignored.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= csd_pkg::MAX_FRAME_RESET;
         min_frame_ff <= csd_pkg::MIN_FRAME_RESET;
         enc_limit_ff <= csd_pkg::ENC_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            csd_pkg::CSR_MAX_FRAME: max_frame_ff <= csr_ch.data;
            csd_pkg::CSR_MIN_FRAME: min_frame_ff <= csr_ch.data;
            csd_pkg::CSR_ENC_LIMIT: enc_limit_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.capacity        = (max_frame_ff < CAP_CEIL) ? max_frame_ff : CAP_CEIL;
      cfg.min_frame_bytes = min_frame_ff;
      cfg.encoded_limit   = enc_limit_ff;
   end

   csd_step u_step (
      .state_cur    (state_ff),
      .cfg          (cfg),
      .wire_byte    (in_byte_ff),
      .gap_before   (in_gap_ff),
      .state_nxt    (state_in),
      .result_valid (step_valid),
      .result       (step_result)
   );

   // The held byte moves on when the result register can take its result, or
   // at once when the byte yields no result. The input register refills in the
   // same cycle, so a byte can be taken every cycle while results flow.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && (out_free || !step_valid);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         in_byte_ff <= req_ch.wire_byte;
         in_gap_ff  <= req_ch.gap_before;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csd_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && step_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance && step_valid) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = rsp_ff.out_byte;
   assign rsp_ch.frame_end    = rsp_ff.frame_end;
   assign rsp_ch.verdict      = rsp_ff.verdict;
   assign rsp_ch.frame_length = rsp_ff.frame_length;

   // A delimiter always leaves a fresh frame behind it.
   a_delim_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_byte_ff == '0 |=>
         state_ff.decoded_count == '0 && state_ff.group_left == '0 &&
         !state_ff.discarding)
      else $error("frame state not cleared after delimiter");

   // While discarding, nothing of the dropped frame is kept.
   a_discard_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff.discarding |->
         state_ff.decoded_count == '0 && state_ff.encoded_count == '0 &&
         !state_ff.zero_owed)
      else $error("discarding with frame state left over");

   // Data transactions carry no verdict and no length.
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.frame_end |->
         rsp_ff.verdict == csd_pkg::VERD_GOOD && rsp_ff.frame_length == '0)
      else $error("data transaction with verdict fields set");

   // Decoded count never passes the number of encoded bytes taken.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.decoded_count <= state_ff.encoded_count)
      else $error("decoded count above encoded count");

endmodule

// ===== src/csd_step.sv =====
// ----------------------------------------------------------------------------
// csd_step
// Next-state and result logic for one wire byte of the COBS deframer.
// ----------------------------------------------------------------------------
module csd_step (
   input  csd_pkg::state_type           state_cur,
   input  csd_pkg::config_type          cfg,
   input  logic [csd_pkg::BYTE_W-1:0]   wire_byte,
   input  logic                         gap_before,
   output csd_pkg::state_type           state_nxt,
   output logic                         result_valid,
   output csd_pkg::result_type          result
);

   csd_pkg::state_type s;
   logic               is_code;
   logic               want_emit;
   logic [csd_pkg::BYTE_W-1:0]  emit_value;
   logic [csd_pkg::VERD_W-1:0]  emit_err;

   always_comb begin
      s            = state_cur;
      result_valid = 1'b0;
      result       = '0;
      is_code      = 1'b0;
      want_emit    = 1'b0;
      emit_value   = '0;
      emit_err     = csd_pkg::ERR_NONE;

      if (gap_before) begin
         s            = csd_pkg::clear_frame(s);
         s.discarding = 1'b1;
      end

      if (wire_byte == '0) begin
         // Delimiter: give the verdict for the frame and start over.
         result_valid    = 1'b1;
         result.frame_end = 1'b1;
         if (s.discarding) begin
            result.verdict = csd_pkg::VERD_RESYNC;
            s.discarding   = 1'b0;
         end else if (s.encoded_count == '0) begin
            result.verdict = csd_pkg::VERD_EMPTY;
         end else begin
            result.frame_length = s.decoded_count;
            if (s.frame_error == csd_pkg::ERR_LARGE_IN_GROUP) begin
               result.verdict = (s.group_left != '0) ? csd_pkg::VERD_MALFORMED
                                                     : csd_pkg::VERD_TOO_LARGE;
            end else if (s.frame_error != csd_pkg::ERR_NONE) begin
               result.verdict = s.frame_error;
            end else if (s.group_left != '0) begin
               result.verdict = csd_pkg::VERD_MALFORMED;
            end else if (s.decoded_count < cfg.min_frame_bytes) begin
               result.verdict = csd_pkg::VERD_TOO_SHORT;
            end else begin
               result.verdict = csd_pkg::VERD_GOOD;
            end
         end
         s = csd_pkg::clear_frame(s);
      end else if (!s.discarding) begin
         if (s.encoded_count >= cfg.encoded_limit) begin
            s            = csd_pkg::clear_frame(s);
            s.discarding = 1'b1;
         end else begin
            s.encoded_count = s.encoded_count + 1'b1;
            is_code = (s.group_left == '0);
            if (is_code) begin
               if (s.frame_error == csd_pkg::ERR_LARGE_IN_GROUP) begin
                  s.frame_error = csd_pkg::ERR_TOO_LARGE;
               end
               want_emit  = s.zero_owed;
               emit_value = '0;
               emit_err   = csd_pkg::ERR_TOO_LARGE;
            end else begin
               want_emit  = 1'b1;
               emit_value = wire_byte;
               emit_err   = csd_pkg::ERR_LARGE_IN_GROUP;
            end

            // A decoded byte goes out only while the frame is clean and fits.
            if (want_emit && s.frame_error == csd_pkg::ERR_NONE) begin
               if (s.decoded_count >= cfg.capacity) begin
                  s.frame_error = emit_err;
               end else begin
                  s.decoded_count = s.decoded_count + 1'b1;
                  result_valid    = 1'b1;
                  result.out_byte = emit_value;
               end
            end

            if (is_code) begin
               s.group_left     = wire_byte - 1'b1;
               s.group_was_full = (wire_byte == csd_pkg::CODE_FULL_GROUP);
            end else begin
               s.group_left = s.group_left - 1'b1;
            end
            s.zero_owed = (s.group_left == '0) ? !s.group_was_full : 1'b0;
         end
      end

      state_nxt = s;
   end

endmodule
